@@ sv/tli_pkg.sv @@
// Shared types and constants for the table linear interpolator.
package tli_pkg;

  localparam int DATA_W          = 32;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int MUL_STEPS       = 32;
  localparam int DIV_STEPS       = 64;
  localparam int STEP_W          = 7;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_WALK,
    S_DECIDE,
    S_CALC,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

endpackage

@@ sv/table_linear_interpolator_unit.sv @@
// Top level: sequencer for table clear/append/query with linear interpolation.
//
//   channel   ports                       handshake
//   --------  --------------------------  -------------------------------------
//   command   action, key, value          taken when start is high, busy low
//   result    result, status              valid for the one cycle done is high
//
// Clear, append and unused-code items give their result in the cycle after start.
// A query with N stored entries reads one entry per cycle, then takes a decision in
// S_DECIDE and gives its result from S_OUT; an interpolating query first runs 32
// multiply steps and 64 divide steps in tli_muldiv before S_OUT.
// busy stays high through the done cycle. rst is synchronous and empties the table.
// Results cannot be stalled.
module table_linear_interpolator_unit #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic signed [tli_pkg::DATA_W-1:0] key,
  input  logic signed [tli_pkg::DATA_W-1:0] value,
  output logic                              done,
  output logic signed [tli_pkg::DATA_W-1:0] result,
  output logic [1:0]                        status
);

  localparam int W      = tli_pkg::DATA_W;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  tli_pkg::seq_state_t state, state_next;

  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic signed [W-1:0] key_q, key_next;
  logic signed [W-1:0] lk, lk_next, lv, lv_next;
  logic signed [W-1:0] hk, hk_next, hv, hv_next;
  logic                neg, neg_next;
  logic signed [W-1:0] res, res_next;
  logic [1:0]          stat, stat_next;

  logic                wr_en;
  logic signed [W-1:0] rd_key, rd_value;
  logic                md_go, md_done;
  logic [W-1:0]        md_a, md_b, md_d, md_q;

  logic                lo_take, hi_take, more;
  logic signed [W:0]   dv_diff, t_diff, d_diff;

  tli_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (count[ADDR_W-1:0]),
    .wr_key   (key),
    .wr_value (value),
    .rd_addr  (idx_next[ADDR_W-1:0]),
    .rd_key   (rd_key),
    .rd_value (rd_value)
  );

  tli_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .go       (md_go),
    .mcand    (md_a),
    .mplier   (md_b),
    .divisor  (md_d),
    .done     (md_done),
    .quotient (md_q)
  );

  assign lo_take = (rd_key <= key_q) && ((rd_key > lk) || (lk > key_q));
  assign hi_take = (rd_key >= key_q) && ((rd_key < hk) || (hk < key_q));
  assign more    = (idx + CNT_W'(1)) < count;

  assign dv_diff = {hv[W-1], hv} - {lv[W-1], lv};
  assign t_diff  = {key_q[W-1], key_q} - {lk[W-1], lk};
  assign d_diff  = {hk[W-1], hk} - {lk[W-1], lk};

  // |hv - lv| always fits W unsigned bits
  assign md_a = dv_diff[W] ? W'(-dv_diff) : dv_diff[W-1:0];
  assign md_b = t_diff[W-1:0];
  assign md_d = d_diff[W-1:0];

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    key_next   = key_q;
    lk_next    = lk;
    lv_next    = lv;
    hk_next    = hk;
    hv_next    = hv;
    neg_next   = neg;
    res_next   = res;
    stat_next  = stat;
    wr_en      = 1'b0;
    md_go      = 1'b0;
    case (state)
      tli_pkg::S_IDLE: begin
        if (start) begin
          res_next   = '0;
          stat_next  = tli_pkg::STAT_DONE;
          state_next = tli_pkg::S_OUT;
          case (action)
            tli_pkg::ACT_CLEAR: count_next = '0;
            tli_pkg::ACT_APPEND: begin
              if (count >= CNT_W'(TABLE_DEPTH)) begin
                stat_next = tli_pkg::STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            tli_pkg::ACT_QUERY: begin
              if (count == '0) begin
                stat_next = tli_pkg::STAT_EMPTY;
              end else begin
                idx_next   = '0;
                key_next   = key;
                state_next = tli_pkg::S_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      tli_pkg::S_FIRST: begin
        lk_next = rd_key;
        lv_next = rd_value;
        hk_next = rd_key;
        hv_next = rd_value;
        if (more) begin
          idx_next   = idx + CNT_W'(1);
          state_next = tli_pkg::S_WALK;
        end else begin
          state_next = tli_pkg::S_DECIDE;
        end
      end
      tli_pkg::S_WALK: begin
        if (lo_take) begin
          lk_next = rd_key;
          lv_next = rd_value;
        end
        if (hi_take) begin
          hk_next = rd_key;
          hv_next = rd_value;
        end
        if (more) begin
          idx_next = idx + CNT_W'(1);
        end else begin
          state_next = tli_pkg::S_DECIDE;
        end
      end
      tli_pkg::S_DECIDE: begin
        if (key_q <= lk) begin
          res_next   = hv;
          state_next = tli_pkg::S_OUT;
        end else if (key_q >= hk) begin
          res_next   = lv;
          state_next = tli_pkg::S_OUT;
        end else begin
          neg_next   = dv_diff[W];
          md_go      = 1'b1;
          state_next = tli_pkg::S_CALC;
        end
      end
      tli_pkg::S_CALC: begin
        if (md_done) begin
          res_next   = neg ? (lv - $signed(md_q)) : (lv + $signed(md_q));
          state_next = tli_pkg::S_OUT;
        end
      end
      tli_pkg::S_OUT: state_next = tli_pkg::S_IDLE;
      default: state_next = tli_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tli_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    key_q <= key_next;
    lk    <= lk_next;
    lv    <= lv_next;
    hk    <= hk_next;
    hv    <= hv_next;
    neg   <= neg_next;
    res   <= res_next;
    stat  <= stat_next;
  end

  assign busy   = (state != tli_pkg::S_IDLE);
  assign done   = (state == tli_pkg::S_OUT);
  assign result = res;
  assign status = stat;

endmodule

@@ sv/tli_table.sv @@
// Key/value entry store: one write port, one registered read port.
module tli_table #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ADDR_W-1:0]                wr_addr,
  input  logic signed [tli_pkg::DATA_W-1:0] wr_key,
  input  logic signed [tli_pkg::DATA_W-1:0] wr_value,
  input  logic [ADDR_W-1:0]                rd_addr,
  output logic signed [tli_pkg::DATA_W-1:0] rd_key,
  output logic signed [tli_pkg::DATA_W-1:0] rd_value
);

  logic [2*tli_pkg::DATA_W-1:0] mem [TABLE_DEPTH];
  logic [2*tli_pkg::DATA_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, wr_value};
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
  end

  assign rd_key   = rd_word[2*tli_pkg::DATA_W-1:tli_pkg::DATA_W];
  assign rd_value = rd_word[tli_pkg::DATA_W-1:0];

endmodule

@@ sv/tli_muldiv.sv @@
// Unsigned floor(a*b/d): shift-add multiply then restoring divide on one shared adder.
module tli_muldiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [tli_pkg::DATA_W-1:0]  mcand,
  input  logic [tli_pkg::DATA_W-1:0]  mplier,
  input  logic [tli_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [tli_pkg::DATA_W-1:0]  quotient
);

  localparam int W = tli_pkg::DATA_W;

  tli_pkg::md_state_t        md_state, md_state_next;
  logic [2*W-1:0]            prod, prod_next;
  logic [W-1:0]              mpl, mpl_next;
  logic [W-1:0]              mc, mc_next;
  logic [W-1:0]              dv, dv_next;
  logic [W-1:0]              rem, rem_next;
  logic [tli_pkg::STEP_W-1:0] step, step_next;
  logic                      done_next;

  // shared adder / subtractor
  logic [2*W-1:0] opa, opb;
  logic           sub;
  logic [2*W:0]   sum;
  logic [W:0]     rshift;

  assign rshift = {rem, prod[2*W-1]};

  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    if (md_state == tli_pkg::MD_DIV) begin
      opa = {{(W-1){1'b0}}, rshift};
      opb = {{W{1'b0}}, dv};
      sub = 1'b1;
    end else begin
      opa = {prod[2*W-2:0], 1'b0};
      opb = mpl[W-1] ? {{W{1'b0}}, mc} : '0;
    end
    sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{(2*W){1'b0}}, sub};
  end

  always_comb begin
    md_state_next = md_state;
    prod_next     = prod;
    mpl_next      = mpl;
    mc_next       = mc;
    dv_next       = dv;
    rem_next      = rem;
    step_next     = step;
    done_next     = 1'b0;
    case (md_state)
      tli_pkg::MD_IDLE: begin
        if (go) begin
          prod_next     = '0;
          mpl_next      = mplier;
          mc_next       = mcand;
          dv_next       = divisor;
          rem_next      = '0;
          step_next     = '0;
          md_state_next = tli_pkg::MD_MUL;
        end
      end
      tli_pkg::MD_MUL: begin
        prod_next = sum[2*W-1:0];
        mpl_next  = {mpl[W-2:0], 1'b0};
        if (step == tli_pkg::STEP_W'(tli_pkg::MUL_STEPS - 1)) begin
          step_next     = '0;
          md_state_next = tli_pkg::MD_DIV;
        end else begin
          step_next = step + 1'b1;
        end
      end
      tli_pkg::MD_DIV: begin
        // carry out set means the shifted remainder reached the divisor
        rem_next  = sum[2*W] ? sum[W-1:0] : rshift[W-1:0];
        prod_next = {prod[2*W-2:0], sum[2*W]};
        if (step == tli_pkg::STEP_W'(tli_pkg::DIV_STEPS - 1)) begin
          done_next     = 1'b1;
          md_state_next = tli_pkg::MD_IDLE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: md_state_next = tli_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      md_state <= tli_pkg::MD_IDLE;
      done     <= 1'b0;
    end else begin
      md_state <= md_state_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    mpl  <= mpl_next;
    mc   <= mc_next;
    dv   <= dv_next;
    rem  <= rem_next;
    step <= step_next;
  end

  assign quotient = prod[W-1:0];

endmodule
